/* rtl/core/block_downscale_8x8_to_5x5_defines.svh */
// assertion macros shared by the 8x8-to-5x5 downscaler rtl
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef BLOCK_DOWNSCALE_8X8_TO_5X5_DEFINES_SVH
`define BLOCK_DOWNSCALE_8X8_TO_5X5_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold on every clock edge outside reset
`define BDS_ASSERT(name, ck, rst_n, prop, msg) \
	name: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define BDS_ASSERT_NEVER(name, ck, rst_n, expr, msg) \
	name: assert property (@(posedge ck) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BDS_ASSERT(name, ck, rst_n, prop, msg)
`define BDS_ASSERT_NEVER(name, ck, rst_n, expr, msg)
`endif

`endif

/* rtl/core/bds_pkg.sv */
// constants, types and channel mixing functions of the 8x8-to-5x5 downscaler
// no dependencies; used by every module of the block
`default_nettype none

package bds_pkg;

	localparam int SRC_WIDTH  = 256;
	localparam int BLOCK_COLS = 32;
	localparam int BLOCK_ROWS = 48;
	localparam int TILE_OUT   = 5;
	localparam int GRP_LEN    = 8;
	localparam int FRAME_ROWS = BLOCK_ROWS * GRP_LEN;

	localparam int COL_W = $clog2(SRC_WIDTH);
	localparam int ROW_W = $clog2(FRAME_ROWS);
	localparam int BX_W  = COL_W - 3;
	localparam int TY_W  = ROW_W - 3;
	localparam int IDX_W = (BLOCK_COLS > 1) ? $clog2(BLOCK_COLS) : 1;
	localparam int CNT_W = $clog2(TILE_OUT + 1);

	localparam int PIX_IN_W  = 15;
	localparam int PIX_OUT_W = 16;
	localparam int DX_W      = 9;
	localparam int DY_W      = 8;
	localparam int CFG_W     = 8;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 40;

	localparam logic [CFG_W-1:0] X_OFFSET_RST = 8'd80;
	localparam logic [2:0]       GRP_LAST     = 3'd7;

	typedef logic [PIX_IN_W-1:0] pix555_t;
	typedef logic [PIX_OUT_W-1:0] pix565_t;
	typedef logic [TILE_OUT-1:0][PIX_IN_W-1:0] hrow_t;
	typedef logic [GRP_LEN-1:0][PIX_IN_W-1:0] grp_t;
	typedef logic [2:0] wgt_t;
	typedef logic [1:0] shf_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} chan_t;

	// output burst buffer status seen by the top level
	typedef struct packed {
		logic             empty;
		logic [CNT_W-1:0] count;
	} obuf_stat_t;

	// weighted sum of three 5-bit channels expanded to 8 bits, then shifted
	function automatic logic [7:0] wsum(input logic [4:0] a, input logic [4:0] b,
			input logic [4:0] c, input wgt_t wa, input wgt_t wb, input wgt_t wc,
			input shf_t sh);
		logic [10:0] s;
		s = 11'({a, 3'b000}) * 11'(wa) + 11'({b, 3'b000}) * 11'(wb)
			+ 11'({c, 3'b000}) * 11'(wc);
		return 8'(s >> sh);
	endfunction

	function automatic chan_t mix(input pix555_t x, input pix555_t y, input pix555_t z,
			input wgt_t wx, input wgt_t wy, input wgt_t wz, input shf_t sh);
		chan_t m;
		m.r = wsum(x[4:0], y[4:0], z[4:0], wx, wy, wz, sh);
		m.g = wsum(x[9:5], y[9:5], z[9:5], wx, wy, wz, sh);
		m.b = wsum(x[14:10], y[14:10], z[14:10], wx, wy, wz, sh);
		return m;
	endfunction

	function automatic pix555_t pack555(input chan_t m);
		return {m.b[7:3], m.g[7:3], m.r[7:3]};
	endfunction

	function automatic pix565_t pack565(input chan_t m);
		return {m.r[7:3], m.g[7:2], m.b[7:3]};
	endfunction

	// horizontal 8-to-5 reduction of one group of a row
	function automatic hrow_t hreduce(input grp_t p);
		hrow_t h;
		h[0] = pack555(mix(p[0], p[1], '0, 3'd5, 3'd3, 3'd0, 2'd3));
		h[1] = pack555(mix(p[1], p[2], p[3], 3'd2, 3'd5, 3'd1, 2'd3));
		h[2] = pack555(mix(p[3], p[4], '0, 3'd1, 3'd1, 3'd0, 2'd1));
		h[3] = pack555(mix(p[4], p[5], p[6], 3'd1, 3'd5, 3'd2, 2'd3));
		h[4] = pack555(mix(p[6], p[7], '0, 3'd3, 3'd5, 3'd0, 2'd3));
		return h;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/bds_row_store.sv */
// two row slots of horizontally reduced values, one tile row of bx entries each
// depends on bds_pkg
`default_nettype none

module bds_row_store (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     wr_slot,
	input  wire logic [bds_pkg::IDX_W-1:0] wr_addr,
	input  wire bds_pkg::hrow_t           wr_data,
	input  wire logic [bds_pkg::IDX_W-1:0] rd_addr,
	output bds_pkg::hrow_t                rd_data0,
	output bds_pkg::hrow_t                rd_data1
);
	import bds_pkg::*;

	hrow_t mem0 [BLOCK_COLS];
	hrow_t mem1 [BLOCK_COLS];

	always_ff @(posedge clk) begin
		if (we && !wr_slot) begin
			mem0[wr_addr] <= wr_data;
		end
		if (we && wr_slot) begin
			mem1[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data0 <= mem0[rd_addr];
		rd_data1 <= mem1[rd_addr];
	end

endmodule

`default_nettype wire

/* rtl/core/bds_out_buf.sv */
// five-word burst buffer draining one result word per cycle to the master while m_tready
// depends on bds_pkg
`default_nettype none

module bds_out_buf (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    load,
	input  wire logic [bds_pkg::TILE_OUT-1:0][bds_pkg::PIX_OUT_W-1:0] ld_pix,
	input  wire logic [bds_pkg::TILE_OUT-1:0][bds_pkg::DX_W-1:0]      ld_x,
	input  wire logic [bds_pkg::DY_W-1:0]               ld_y,
	output bds_pkg::obuf_stat_t                          stat,
	output logic                                         m_tvalid,
	input  wire logic                                    m_tready,
	output logic [bds_pkg::M_TDATA_W-1:0]                m_tdata,
	output logic                                         m_tlast
);
	import bds_pkg::*;

	pix565_t           pix_q [TILE_OUT];
	logic [DX_W-1:0]   x_q [TILE_OUT];
	logic [DY_W-1:0]   y_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pop;

	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= CNT_W'(TILE_OUT);
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// shift line: word 0 is the one on the bus
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < TILE_OUT; i++) begin
				pix_q[i] <= ld_pix[i];
				x_q[i]   <= ld_x[i];
			end
			y_q <= ld_y;
		end else if (pop) begin
			for (int i = 0; i < TILE_OUT - 1; i++) begin
				pix_q[i] <= pix_q[i+1];
				x_q[i]   <= x_q[i+1];
			end
		end
	end

	assign m_tvalid   = (cnt_q != '0);
	assign m_tlast    = (cnt_q == CNT_W'(1));
	assign m_tdata    = M_TDATA_W'({y_q, x_q[0], pix_q[0]});
	assign stat.empty = (cnt_q == '0);
	assign stat.count = cnt_q;

endmodule

`default_nettype wire

/* rtl/core/block_downscale_8x8_to_5x5.sv */
// top level of the 8x8-to-5x5 area-weighted downscaler
// depends on bds_pkg, bds_row_store, bds_out_buf and the assertion macro header
//
// usage:
//  - slave side takes one BGR555 source pixel per word in raster order, 256 a row,
//    384 rows a frame; tuser marks the first pixel of a frame and restarts the counters
//  - every eighth pixel of a row closes a group: its 8 pixels are reduced to 5
//    values and kept in a two-slot row store (one memory per slot, 32 x 75 bits)
//  - in tile rows 1, 3, 4, 6 and 7 a closed group also makes a burst of five
//    RGB565 result words with destination column and row; tlast marks the fifth
//  - the first word of a burst is valid once stage 1 has loaded it into the
//    burst buffer; the burst drains one word a cycle while the receiver is ready
//  - throughput is one pixel per cycle while the buffer keeps up; five words per
//    eight pixels fit that rate, so a receiver that never stalls never slows the slave side
//  - the burst buffer holds one burst; while it still holds words, the slave side
//    stalls only on a pixel that would close a group
//  - cfg channel writes x_offset (always ready); write it only while idle
//  - reset clears counters and empties the burst buffer, x_offset goes to 80;
//    the row store is not cleared and is always written before it is read
`default_nettype none
`include "block_downscale_8x8_to_5x5_defines.svh"

module block_downscale_8x8_to_5x5 (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write: x_offset
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [bds_pkg::CFG_W-1:0]       cfg_data,
	// source pixels
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [bds_pkg::S_TDATA_W-1:0]   s_tdata,   // pixel_in[14:0], zero pad
	input  wire logic                            s_tuser,   // frame_start
	// destination pixels
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [bds_pkg::M_TDATA_W-1:0]        m_tdata,   // pixel_out[15:0],
	                                                        // dest_x[24:16],
	                                                        // dest_y[32:25], zero pad
	output logic                                 m_tlast    // last
);
	import bds_pkg::*;

	// configuration register
	logic [CFG_W-1:0] x_off_q;

	// position counters and group pixels of the current row
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	pix555_t          grp_q [GRP_LEN-1];

	// input side decode
	logic             acc;
	logic [COL_W-1:0] eff_col;
	logic [ROW_W-1:0] eff_row;
	logic [2:0]       grp_pos;
	logic             grp_end;
	logic [BX_W-1:0]  bx;
	logic             bx_ok;
	logic [COL_W:0]   col_inc;
	logic [ROW_W:0]   row_inc;
	pix555_t          pix;
	grp_t             grp_all;
	hrow_t            h_next;

	// stage 1: reduced group plus row store read data
	logic             v_s1;
	hrow_t            h_s1;
	logic [IDX_W-1:0] bx_s1;
	logic [2:0]       ry_s1;
	logic [TY_W-1:0]  ty_s1;
	hrow_t            rd0_s1;
	hrow_t            rd1_s1;
	logic             ld_s1;
	logic             wr_s1;
	logic             slot_s1;

	// vertical combine
	logic             three_tap;
	wgt_t             wa;
	wgt_t             wb;
	wgt_t             wc;
	shf_t             sh;
	logic [2:0]       oy;
	logic [TILE_OUT-1:0][PIX_OUT_W-1:0] ld_pix;
	logic [TILE_OUT-1:0][DX_W-1:0]      ld_x;
	logic [DY_W-1:0]  ld_y;
	obuf_stat_t       ob_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off_q <= X_OFFSET_RST;
		end else if (cfg_valid) begin
			x_off_q <= cfg_data;
		end
	end

	// a pixel that closes a group waits while a burst loads and until the last one has fully drained
	assign s_tready = (col_q[2:0] != GRP_LAST) || (!ld_s1 && ob_stat.empty);
	assign acc      = s_tvalid && s_tready;

	// frame start puts this pixel at column 0, row 0
	assign eff_col = s_tuser ? '0 : col_q;
	assign eff_row = s_tuser ? '0 : row_q;
	assign grp_pos = eff_col[2:0];
	assign grp_end = (grp_pos == GRP_LAST);
	assign bx      = eff_col[COL_W-1:3];
	assign bx_ok   = (32'(bx) < BLOCK_COLS);
	assign pix     = s_tdata[PIX_IN_W-1:0];
	assign col_inc = {1'b0, eff_col} + 1'b1;
	assign row_inc = {1'b0, eff_row} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (32'(col_inc) >= SRC_WIDTH) begin
				col_q <= '0;
				row_q <= (32'(row_inc) >= FRAME_ROWS) ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !grp_end) begin
			grp_q[grp_pos] <= pix;
		end
	end

	// horizontal pass straight from the group registers and the closing pixel
	always_comb begin
		for (int i = 0; i < GRP_LEN - 1; i++) begin
			grp_all[i] = grp_q[i];
		end
		grp_all[GRP_LEN-1] = pix;
		h_next = hreduce(grp_all);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc && grp_end && bx_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && grp_end) begin
			h_s1  <= h_next;
			bx_s1 <= IDX_W'(bx);
			ry_s1 <= eff_row[2:0];
			ty_s1 <= eff_row[ROW_W-1:3];
		end
	end

	// rows 2 and 5 go to the second slot, rows 0, 1, 3, 4 and 6 to the first;
	// the last row of a tile is only consumed
	assign wr_s1   = v_s1 && (ry_s1 != 3'd7);
	assign slot_s1 = (ry_s1 == 3'd2) || (ry_s1 == 3'd5);
	assign ld_s1   = v_s1 && (ry_s1 inside {3'd1, 3'd3, 3'd4, 3'd6, 3'd7});

	// read is issued with the closing pixel, data lands with stage 1
	bds_row_store u_row_store (
		.clk      (clk),
		.we       (wr_s1),
		.wr_slot  (slot_s1),
		.wr_addr  (bx_s1),
		.wr_data  (h_s1),
		.rd_addr  (IDX_W'(bx)),
		.rd_data0 (rd0_s1),
		.rd_data1 (rd1_s1)
	);

	// vertical weights by row within the tile
	always_comb begin
		three_tap = 1'b0;
		wa = 3'd3;
		wb = 3'd5;
		wc = 3'd0;
		sh = 2'd3;
		oy = 3'd4;
		case (ry_s1)
			3'd1: begin
				wa = 3'd5; wb = 3'd3; oy = 3'd0;
			end
			3'd3: begin
				three_tap = 1'b1; wa = 3'd2; wb = 3'd5; wc = 3'd1; oy = 3'd1;
			end
			3'd4: begin
				wa = 3'd1; wb = 3'd1; sh = 2'd1; oy = 3'd2;
			end
			3'd6: begin
				three_tap = 1'b1; wa = 3'd1; wb = 3'd5; wc = 3'd2; oy = 3'd3;
			end
			default: begin
				// last row of the tile: 3:5 with the first slot
			end
		endcase
	end

	always_comb begin
		for (int k = 0; k < TILE_OUT; k++) begin
			ld_pix[k] = pack565(mix(rd0_s1[k], three_tap ? rd1_s1[k] : h_s1[k],
				three_tap ? h_s1[k] : '0, wa, wb, wc, sh));
			ld_x[k] = DX_W'(x_off_q) + DX_W'(bx_s1) * DX_W'(TILE_OUT) + DX_W'(k);
		end
		ld_y = DY_W'(9'(ty_s1) * 9'(TILE_OUT) + 9'(oy));
	end

	bds_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (ld_s1),
		.ld_pix   (ld_pix),
		.ld_x     (ld_x),
		.ld_y     (ld_y),
		.stat     (ob_stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// a burst never lands on words still waiting in the buffer
	`BDS_ASSERT(a_load_into_empty, clk, arst_n, ld_s1 |-> ob_stat.empty, "burst overwrote buffer")
	// the slave side only stalls on a pixel that would close a group
	`BDS_ASSERT(a_stall_at_group_end, clk, arst_n, !s_tready |-> (col_q[2:0] == GRP_LAST), "stall off group end")
	// the row counter stays within the frame
	`BDS_ASSERT_NEVER(a_row_range, clk, arst_n, 32'(row_q) >= FRAME_ROWS, "row counter out of range")
	// a closing pixel in the last row of a tile always produces a burst next cycle
	`BDS_ASSERT(a_burst_follows, clk, arst_n, (acc && grp_end && bx_ok && (eff_row[2:0] == 3'd7)) |=> ld_s1, "missing burst")

endmodule

`default_nettype wire

/* bench/block_downscale_8x8_to_5x5_tb.sv */
// self-checking bench for the 8x8-to-5x5 downscaler: a queue-fed source driver, a stalling sink
// and a predictor of the two-pass reduction that checks every result word in order
// depends on bds_pkg and block_downscale_8x8_to_5x5
module block_downscale_8x8_to_5x5_tb;

	localparam int SRC_W      = bds_pkg::SRC_WIDTH;
	localparam int TILE_COLS  = bds_pkg::BLOCK_COLS;
	localparam int FRAME_ROWS = bds_pkg::FRAME_ROWS;
	localparam int TILE_OUT   = bds_pkg::TILE_OUT;
	localparam int ROW_SLOT   = TILE_OUT * TILE_COLS;

	// field positions inside m_tdata
	localparam int PIX_W  = bds_pkg::PIX_OUT_W;
	localparam int DX_LSB = PIX_W;
	localparam int DY_LSB = DX_LSB + bds_pkg::DX_W;

	localparam int     MAX_GAP       = 4;
	localparam int     SETTLE_CYCLES = 16;
	localparam int     DRAIN_CYCLES  = 32;
	localparam int     MAX_REPORTS   = 50;
	localparam longint CYCLE_LIMIT   = 100_000;

	// row position inside an 8-row tile
	localparam logic [2:0] ROW_OUT0      = 3'd1;
	localparam logic [2:0] ROW_MID_STORE = 3'd2;
	localparam logic [2:0] ROW_OUT1      = 3'd3;
	localparam logic [2:0] ROW_OUT2      = 3'd4;
	localparam logic [2:0] ROW_LOW_STORE = 3'd5;
	localparam logic [2:0] ROW_OUT3      = 3'd6;
	localparam logic [2:0] ROW_OUT4      = 3'd7;

	// sink stall patterns
	localparam int RX_OPEN      = 0;
	localparam int RX_ALTERNATE = 1;
	localparam int RX_COIN      = 2;
	localparam int RX_SPARSE    = 3;

	typedef bds_pkg::pix555_t pix555_t;
	typedef bds_pkg::pix565_t pix565_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb8_t;

	typedef struct {
		pix555_t pix;
		bit      frame_start;
		bit      wait_drain;   // hold this word back until every result has come
	} src_pixel_t;

	typedef struct {
		pix565_t                   pixel;
		logic [bds_pkg::DX_W-1:0]  dest_x;
		logic [bds_pkg::DY_W-1:0]  dest_y;
		bit                        last;
	} out_word_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [bds_pkg::CFG_W-1:0]     cfg_data;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [bds_pkg::S_TDATA_W-1:0] s_tdata;   // pixel_in[14:0], zero pad
	logic                          s_tuser;   // frame_start
	logic                          m_tvalid;
	logic                          m_tready;
	logic [bds_pkg::M_TDATA_W-1:0] m_tdata;   // pixel_out[15:0], dest_x[24:16], dest_y[32:25]
	logic                          m_tlast;   // last

	block_downscale_8x8_to_5x5 DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// predictor state: scan position, open group, two slots of reduced rows, offset
	int unsigned      scan_col;
	int unsigned      scan_row;
	pix555_t          group_px [7];
	pix555_t          hrow_store [2*ROW_SLOT];
	logic [7:0]       x_offset_shadow;

	out_word_t        expected_words [$];
	src_pixel_t       pixel_queue [$];
	src_pixel_t       next_pixel;

	// handshakes seen at the last rising edge, used by the falling-edge drivers
	bit               src_fire;
	bit               cfg_fire;

	int               burst_left;
	int               gap_left;
	int               rx_window;
	int               rx_mode;
	bit               rx_toggle;
	int               errors;
	int               reports;
	longint           cycle_count;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// per-channel weighted sum of up to three BGR555 pixels, 5-bit channels widened to 8
	function automatic rgb8_t blend(input pix555_t x, input pix555_t y, input pix555_t z,
			input int unsigned wx, input int unsigned wy, input int unsigned wz,
			input int unsigned sh);
		rgb8_t m;
		m.r = 8'((32'(x[4:0]) * 8 * wx + 32'(y[4:0]) * 8 * wy + 32'(z[4:0]) * 8 * wz) >> sh);
		m.g = 8'((32'(x[9:5]) * 8 * wx + 32'(y[9:5]) * 8 * wy + 32'(z[9:5]) * 8 * wz) >> sh);
		m.b = 8'((32'(x[14:10]) * 8 * wx + 32'(y[14:10]) * 8 * wy
			+ 32'(z[14:10]) * 8 * wz) >> sh);
		return m;
	endfunction

	function automatic pix555_t to_bgr555(input rgb8_t m);
		return (15'(m.b & 8'hf8) << 7) | (15'(m.g & 8'hf8) << 2) | (15'(m.r & 8'hf8) >> 3);
	endfunction

	function automatic pix565_t to_rgb565(input rgb8_t m);
		return (16'(m.r & 8'hf8) << 8) | (16'(m.g & 8'hfc) << 3) | (16'(m.b & 8'hf8) >> 3);
	endfunction

	// advance the scan by one accepted pixel and queue the burst it closes, if any
	task automatic downscale_pixel(input pix555_t pix, input bit frame_start);
		int unsigned col;
		int unsigned row;
		int unsigned bx;
		int unsigned base;
		int unsigned dy;
		int unsigned oy;
		int unsigned slot;
		logic [2:0]  ry;
		pix555_t     p [8];
		pix555_t     h [5];
		pix555_t     s0;
		pix555_t     s1;
		rgb8_t       m;
		out_word_t   w;
		bit          emit;

		// a frame start restarts the scan at this very pixel
		if (frame_start) begin
			scan_col = 0;
			scan_row = 0;
		end
		col = scan_col;
		row = scan_row;
		bx  = col >> 3;
		ry  = 3'(row);

		if (3'(col) != bds_pkg::GRP_LAST) begin
			group_px[col % 8] = pix;
		end else if (bx < TILE_COLS) begin
			base = bx * TILE_OUT;
			dy   = (row >> 3) * TILE_OUT;
			for (int k = 0; k < 7; k++)
				p[k] = group_px[k];
			p[7] = pix;

			// horizontal pass, weights 5:3, 2:5:1, 1:1, 1:5:2, 3:5
			h[0] = to_bgr555(blend(p[0], p[1], '0,   5, 3, 0, 3));
			h[1] = to_bgr555(blend(p[1], p[2], p[3], 2, 5, 1, 3));
			h[2] = to_bgr555(blend(p[3], p[4], '0,   1, 1, 0, 1));
			h[3] = to_bgr555(blend(p[4], p[5], p[6], 1, 5, 2, 3));
			h[4] = to_bgr555(blend(p[6], p[7], '0,   3, 5, 0, 3));

			// vertical pass against the stored rows of this tile column
			for (int k = 0; k < TILE_OUT; k++) begin
				s0   = hrow_store[base + k];
				s1   = hrow_store[ROW_SLOT + base + k];
				emit = 1'b1;
				oy   = 0;
				m    = '0;
				case (ry)
					ROW_OUT0: begin
						m  = blend(s0, h[k], '0, 5, 3, 0, 3);
						oy = 0;
					end
					ROW_OUT1: begin
						m  = blend(s0, s1, h[k], 2, 5, 1, 3);
						oy = 1;
					end
					ROW_OUT2: begin
						m  = blend(s0, h[k], '0, 1, 1, 0, 1);
						oy = 2;
					end
					ROW_OUT3: begin
						m  = blend(s0, s1, h[k], 1, 5, 2, 3);
						oy = 3;
					end
					ROW_OUT4: begin
						m  = blend(s0, h[k], '0, 3, 5, 0, 3);
						oy = 4;
					end
					default: emit = 1'b0;
				endcase
				if (emit) begin
					w.pixel  = to_rgb565(m);
					w.dest_x = 9'(32'(x_offset_shadow) + base + k);
					w.dest_y = 8'(dy + oy);
					w.last   = (k == TILE_OUT - 1);
					expected_words.push_back(w);
				end
			end

			// rows 2 and 5 go to the second slot, the last row is never stored
			if (ry != ROW_OUT4) begin
				slot = (ry == ROW_MID_STORE || ry == ROW_LOW_STORE) ? ROW_SLOT : 0;
				for (int k = 0; k < TILE_OUT; k++)
					hrow_store[slot + base + k] = h[k];
			end
		end

		scan_col = col + 1;
		if (scan_col >= SRC_W) begin
			scan_col = 0;
			scan_row = row + 1;
			if (scan_row >= FRAME_ROWS)
				scan_row = 0;
		end
	endtask

	// compare one accepted result word with the oldest expectation
	task automatic check_word();
		out_word_t w;
		pix565_t   act_pixel;
		logic [bds_pkg::DX_W-1:0] act_x;
		logic [bds_pkg::DY_W-1:0] act_y;

		act_pixel = m_tdata[PIX_W-1:0];
		act_x     = m_tdata[DX_LSB +: bds_pkg::DX_W];
		act_y     = m_tdata[DY_LSB +: bds_pkg::DY_W];
		if (expected_words.size() == 0) begin
			errors++;
			if (reports < MAX_REPORTS) begin
				reports++;
				$display("%0t: unexpected word, expected none, actual pixel %h x %0d y %0d last %b",
					$time, act_pixel, act_x, act_y, m_tlast);
			end
		end else begin
			w = expected_words.pop_front();
			if (act_pixel !== w.pixel || act_x !== w.dest_x || act_y !== w.dest_y
					|| m_tlast !== w.last) begin
				errors++;
				// reporting is capped so a broken build cannot flood the log
				if (reports < MAX_REPORTS) begin
					reports++;
					$display("%0t: word mismatch, expected pixel %h x %0d y %0d last %b, actual pixel %h x %0d y %0d last %b",
						$time, w.pixel, w.dest_x, w.dest_y, w.last,
						act_pixel, act_x, act_y, m_tlast);
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// monitor: everything is sampled at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			src_fire = s_tvalid && s_tready;
			cfg_fire = cfg_valid && cfg_ready;
			if (cfg_fire)
				x_offset_shadow = cfg_data;
			if (src_fire)
				downscale_pixel(s_tdata[bds_pkg::PIX_IN_W-1:0], s_tuser);
			if (m_tvalid && m_tready)
				check_word();
		end
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached with %0d words outstanding",
				$time, expected_words.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// source driver: bursts of random length with random gaps, changes at the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || src_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pixel_queue.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (pixel_queue[0].wait_drain && expected_words.size() != 0) begin
				// pause until the sink has taken every outstanding word
				s_tvalid <= 1'b0;
			end else begin
				next_pixel = pixel_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {1'b0, next_pixel.pix};
				s_tuser  <= next_pixel.frame_start;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 64);
					// a quarter of the bursts run straight into the next one
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
				end
			end
		end
	end

	// sink: stall pattern switches between open, alternating, coin-flip and sparse windows
	always @(negedge clk) begin
		if (rx_window == 0) begin
			rx_window = $urandom_range(4, 48);
			rx_mode   = $urandom_range(RX_OPEN, RX_SPARSE);
		end
		rx_window--;
		rx_toggle = !rx_toggle;
		case (rx_mode)
			RX_OPEN:      m_tready <= 1'b1;
			RX_ALTERNATE: m_tready <= rx_toggle;
			RX_COIN:      m_tready <= 1'($urandom_range(0, 1));
			default:      m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	task automatic push_pixel(input pix555_t pix, input bit frame_start, input bit wait_drain);
		src_pixel_t item;
		item.pix         = pix;
		item.frame_start = frame_start;
		item.wait_drain  = wait_drain;
		pixel_queue.push_back(item);
	endtask

	// random colors half the time, black, white and single-channel extremes otherwise
	function automatic pix555_t random_pixel();
		case ($urandom_range(0, 9))
			0:       return 15'h0000;
			1:       return 15'h7fff;
			2:       return 15'h001f;
			3:       return 15'h03e0;
			4:       return 15'h7c00;
			default: return 15'($urandom_range(0, 32767));
		endcase
	endfunction

	// a run of raster pixels; noise is the chance per 4096 of a stray frame start
	task automatic queue_run(input int count, input bit restart, input int noise,
			input bit with_hold);
		int hold_at;
		bit fs;
		hold_at = with_hold ? int'($urandom_range(count / 4, count - 1)) : -1;
		for (int k = 0; k < count; k++) begin
			fs = (k == 0) ? restart : (int'($urandom_range(0, 4095)) < noise);
			push_pixel(random_pixel(), fs, k == hold_at);
		end
	endtask

	// wait until the source is drained and every expected word has arrived
	task automatic wait_idle();
		@(negedge clk);
		while (pixel_queue.size() != 0 || s_tvalid || expected_words.size() != 0)
			@(negedge clk);
	endtask

	// offset writes only happen with the block idle and its pipeline settled
	task automatic write_x_offset(input logic [7:0] value);
		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(negedge clk);
		while (!cfg_fire)
			@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_data        = '0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = 1'b0;
		m_tready        = 1'b0;
		scan_col        = 0;
		scan_row        = 0;
		x_offset_shadow = bds_pkg::X_OFFSET_RST;
		burst_left      = 0;
		gap_left        = 0;
		rx_window       = 0;
		rx_mode         = RX_OPEN;
		rx_toggle       = 1'b0;
		errors          = 0;
		reports         = 0;
		cycle_count     = 0;
		src_fire        = 1'b0;
		cfg_fire        = 1'b0;
		foreach (group_px[i])
			group_px[i] = '0;
		foreach (hrow_store[i])
			hrow_store[i] = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: channel extremes and bit patterns in a closed group, then a frame
		// start in the middle of a group
		push_pixel(15'h7fff, 1'b1, 1'b0);
		push_pixel(15'h0000, 1'b0, 1'b0);
		push_pixel(15'h001f, 1'b0, 1'b0);
		push_pixel(15'h03e0, 1'b0, 1'b0);
		push_pixel(15'h7c00, 1'b0, 1'b0);
		push_pixel(15'h5555, 1'b0, 1'b0);
		push_pixel(15'h2aaa, 1'b0, 1'b0);
		push_pixel(15'h7fff, 1'b0, 1'b0);
		push_pixel(15'h0000, 1'b0, 1'b0);
		push_pixel(15'h7fff, 1'b0, 1'b0);
		push_pixel(15'h1234, 1'b0, 1'b0);
		push_pixel(15'h0001, 1'b1, 1'b0);
		push_pixel(15'h4000, 1'b0, 1'b0);
		push_pixel(15'h0020, 1'b0, 1'b0);
		push_pixel(15'h0400, 1'b0, 1'b0);
		push_pixel(15'h7fff, 1'b0, 1'b0);
		push_pixel(15'h7fff, 1'b0, 1'b0);
		push_pixel(15'h0000, 1'b0, 1'b0);
		push_pixel(15'h0000, 1'b0, 1'b0);
		push_pixel(15'h7fff, 1'b0, 1'b0);

		// a storing source row, then the start of the emitting row at the reset offset
		queue_run(SRC_W + 56, 1'b1, 0, 1'b0);
		// hold the next pixel until the burst of the last group has drained
		push_pixel(random_pixel(), 1'b0, 1'b1);
		queue_run(15, 1'b0, 0, 1'b0);

		// smallest offset, the scan carries on in the same row
		write_x_offset(8'd0);
		queue_run(16, 1'b0, 0, 1'b0);

		// largest centering offset
		write_x_offset(8'd160);
		queue_run(24, 1'b0, 0, 1'b0);

		// all-ones offset
		write_x_offset(8'hff);
		queue_run(24, 1'b0, 0, 1'b0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_words.size() != 0) begin
			errors++;
			$display("%0t: %0d expected words never arrived, next pixel %h x %0d y %0d",
				$time, expected_words.size(), expected_words[0].pixel,
				expected_words[0].dest_x, expected_words[0].dest_y);
		end
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
